// File: rtl/core/olte_pkg.sv
// Shared types and codes for the ordered list table engine.
`default_nettype none

package olte_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DELETE    = 3'd2,
    OP_SEARCH    = 3'd3,
    OP_LIST      = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_ELEMENT   = 3'd6,
    ST_EMPTY     = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FRONT_RD,
    S_FRONT_WR,
    S_FRONT_PUT,
    S_SCAN,
    S_DEL_SHIFT,
    S_LIST
  } state_e;

  typedef enum logic [1:0] {
    WA_COUNT,
    WA_ZERO,
    WA_UP,
    WA_DOWN
  } wa_sel_e;

  typedef enum logic {
    WD_VALUE,
    WD_READ
  } wd_sel_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_TOP,
    IDX_STEP
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         position;
    logic signed [31:0] element;
    logic               last;
  } out_t;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    logic    idx_down;
    idx_op_e idx_op;
    logic    wr_en;
    wa_sel_e wr_addr_sel;
    wd_sel_e wr_data_sel;
    cnt_op_e cnt_op;
    logic    emit;
    status_e emit_status;
    logic    emit_pos;
    logic    emit_elem;
    logic    emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       cnt_zero;
    logic       cnt_full;
    logic       idx_end;
    logic       idx_zero;
    logic       pvld;
    logic       match;
    logic       plast;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/ordered_list_table_engine.sv
// Top level of the ordered list table engine: controller and datapath.
//
//   channel   ports                       transfer
//   command   start, busy, cmd_i          start high while busy low
//   result    res_valid_o, res_o          res_valid_o high, one cycle each
//
// Insert at the back writes the value after the last entry; insert at the front first
// shifts all entries up one place. Delete scans, then shifts later entries down.
// The list memory has one read and one write port with registered read data, so each
// walk or shift moves one entry per cycle. After reset the list is empty at once and
// the memory is not cleared. Results leave at one per cycle and are never held.
`default_nettype none

module ordered_list_table_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire            logic clk_i,
  input  wire            logic rst_ni,
  input  wire            logic start,
  output logic           busy,
  input  wire olte_pkg::in_t cmd_i,
  output olte_pkg::out_t res_o,
  output logic           res_valid_o
);
  import olte_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  olte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (dp_stat),
    .cmd_o  (ctl_cmd),
    .busy_o (busy)
  );

  olte_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (cmd_i),
    .cmd_i      (ctl_cmd),
    .stat_o     (dp_stat),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/olte_dp.sv
// Datapath of the ordered list table engine: list memory, pointers, count, result register.
`default_nettype none

module olte_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire olte_pkg::in_t      item_i,
  input  wire olte_pkg::ctl_cmd_t cmd_i,
  output olte_pkg::dp_stat_t stat_o,
  output olte_pkg::out_t     res_o,
  output logic               res_valid_o
);
  import olte_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  logic [31:0]        mem_q [CAPACITY];
  logic [2:0]         op_q;
  logic signed [31:0] key_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      pidx_q;
  logic               pvld_q;
  logic [31:0]        rdata_q;
  logic [CW-1:0]      wa;
  logic [31:0]        wd;
  logic [CW:0]        pos_w;
  out_t               res_d;
  out_t               res_q;
  logic               res_vld_q;

  always_comb begin
    case (cmd_i.wr_addr_sel)
      WA_COUNT: wa = count_q;
      WA_ZERO:  wa = '0;
      WA_UP:    wa = pidx_q + CW'(1);
      WA_DOWN:  wa = pidx_q - CW'(1);
      default:  wa = '0;
    endcase
    wd = (cmd_i.wr_data_sel == WD_READ) ? rdata_q : key_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wa[IW-1:0]] <= wd;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[idx_q[IW-1:0]];
    end
    if (cmd_i.load_item) begin
      op_q  <= item_i.operation;
      key_q <= item_i.value;
    end
    pidx_q <= idx_q;
    res_q  <= res_d;
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_HOLD: idx_d = idx_q;
      IDX_ZERO: idx_d = '0;
      IDX_TOP:  idx_d = count_q - CW'(1);
      IDX_STEP: idx_d = cmd_i.idx_down ? idx_q - CW'(1) : idx_q + CW'(1);
      default:  idx_d = idx_q;
    endcase
    case (cmd_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CW'(1);
      CNT_DEC:  count_d = count_q - CW'(1);
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      pvld_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      idx_q     <= idx_d;
      pvld_q    <= cmd_i.rd_en;
      res_vld_q <= cmd_i.emit;
    end
  end

  always_comb begin
    pos_w          = {1'b0, pidx_q} + (CW + 1)'(1);
    res_d.status   = cmd_i.emit_status;
    res_d.position = cmd_i.emit_pos ? 5'(pos_w) : 5'd0;
    res_d.element  = cmd_i.emit_elem ? rdata_q : 32'sd0;
    res_d.last     = cmd_i.emit_last;
  end

  assign stat_o.op       = op_q;
  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.cnt_full = (count_q >= CW'(CAPACITY));
  assign stat_o.idx_end  = (idx_q >= count_q);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.pvld     = pvld_q;
  assign stat_o.match    = pvld_q && (rdata_q == key_q);
  assign stat_o.plast    = (pidx_q == count_q - CW'(1));

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> idx_q < count_q)
    else $error("read beyond valid entries");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> wa < CW'(CAPACITY))
    else $error("write beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == CNT_DEC |-> count_q != '0)
    else $error("count decrement on empty list");

endmodule

`default_nettype wire

// File: rtl/core/olte_ctrl.sv
// Controller state machine of the ordered list table engine.
`default_nettype none

module olte_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic start_i,
  input  wire olte_pkg::dp_stat_t stat_i,
  output olte_pkg::ctl_cmd_t cmd_o,
  output logic               busy_o
);
  import olte_pkg::*;

  state_e state_q, state_d;
  op_e    op;

  assign op = op_e'(stat_i.op);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (op)
          OP_INS_FRONT: begin
            if (stat_i.cnt_full)      state_d = S_IDLE;
            else if (stat_i.cnt_zero) state_d = S_FRONT_PUT;
            else                      state_d = S_FRONT_RD;
          end
          OP_INS_BACK:  state_d = S_IDLE;
          OP_DELETE:    state_d = S_SCAN;
          OP_SEARCH:    state_d = S_SCAN;
          OP_LIST:      state_d = stat_i.cnt_zero ? S_IDLE : S_LIST;
          default:      state_d = S_IDLE;
        endcase
      end
      S_FRONT_RD: begin
        if (stat_i.idx_zero) state_d = S_FRONT_WR;
      end
      S_FRONT_WR:  state_d = S_FRONT_PUT;
      S_FRONT_PUT: state_d = S_IDLE;
      S_SCAN: begin
        if (stat_i.match) begin
          state_d = (op == OP_DELETE) ? S_DEL_SHIFT : S_IDLE;
        end else if (stat_i.idx_end && !stat_i.pvld) begin
          state_d = S_IDLE;
        end
      end
      S_DEL_SHIFT: begin
        if (stat_i.idx_end && !stat_i.pvld) state_d = S_IDLE;
      end
      S_LIST: begin
        if (stat_i.pvld && stat_i.plast) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.idx_op      = IDX_HOLD;
    cmd_o.wr_addr_sel = WA_COUNT;
    cmd_o.wr_data_sel = WD_VALUE;
    cmd_o.cnt_op      = CNT_HOLD;
    cmd_o.emit_status = ST_INSERTED;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_item = start_i;
      end
      S_EXEC: begin
        case (op)
          OP_INS_FRONT: begin
            if (stat_i.cnt_full) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = ST_FULL;
              cmd_o.emit_last   = 1'b1;
            end else begin
              cmd_o.idx_op = IDX_TOP;
            end
          end
          OP_INS_BACK: begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            if (stat_i.cnt_full) begin
              cmd_o.emit_status = ST_FULL;
            end else begin
              cmd_o.wr_en       = 1'b1;
              cmd_o.cnt_op      = CNT_INC;
              cmd_o.emit_status = ST_INSERTED;
            end
          end
          OP_DELETE, OP_SEARCH: begin
            cmd_o.idx_op = IDX_ZERO;
          end
          OP_LIST: begin
            if (stat_i.cnt_zero) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = ST_EMPTY;
              cmd_o.emit_last   = 1'b1;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
            end
          end
          default: cmd_o.emit = 1'b0;
        endcase
      end
      S_FRONT_RD: begin
        cmd_o.rd_en       = 1'b1;
        cmd_o.idx_op      = stat_i.idx_zero ? IDX_HOLD : IDX_STEP;
        cmd_o.idx_down    = 1'b1;
        cmd_o.wr_en       = stat_i.pvld;
        cmd_o.wr_addr_sel = WA_UP;
        cmd_o.wr_data_sel = WD_READ;
      end
      S_FRONT_WR: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_addr_sel = WA_UP;
        cmd_o.wr_data_sel = WD_READ;
      end
      S_FRONT_PUT: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_addr_sel = WA_ZERO;
        cmd_o.wr_data_sel = WD_VALUE;
        cmd_o.cnt_op      = CNT_INC;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = ST_INSERTED;
        cmd_o.emit_last   = 1'b1;
      end
      S_SCAN: begin
        cmd_o.rd_en  = !stat_i.idx_end;
        cmd_o.idx_op = stat_i.idx_end ? IDX_HOLD : IDX_STEP;
        if (stat_i.match) begin
          if (op != OP_DELETE) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_FOUND;
            cmd_o.emit_pos    = 1'b1;
            cmd_o.emit_last   = 1'b1;
          end
        end else if (stat_i.idx_end && !stat_i.pvld) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = (op == OP_DELETE) ? ST_ABSENT : ST_NOT_FOUND;
          cmd_o.emit_last   = 1'b1;
        end
      end
      S_DEL_SHIFT: begin
        cmd_o.rd_en       = !stat_i.idx_end;
        cmd_o.idx_op      = stat_i.idx_end ? IDX_HOLD : IDX_STEP;
        cmd_o.wr_en       = stat_i.pvld;
        cmd_o.wr_addr_sel = WA_DOWN;
        cmd_o.wr_data_sel = WD_READ;
        if (stat_i.idx_end && !stat_i.pvld) begin
          cmd_o.cnt_op      = CNT_DEC;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_DELETED;
          cmd_o.emit_last   = 1'b1;
        end
      end
      S_LIST: begin
        cmd_o.rd_en       = !stat_i.idx_end;
        cmd_o.idx_op      = stat_i.idx_end ? IDX_HOLD : IDX_STEP;
        cmd_o.emit        = stat_i.pvld;
        cmd_o.emit_status = ST_ELEMENT;
        cmd_o.emit_pos    = 1'b1;
        cmd_o.emit_elem   = 1'b1;
        cmd_o.emit_last   = stat_i.plast;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> state_q == S_EXEC)
    else $error("accepted item did not start execution");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> busy_o)
    else $error("result issued while idle");

  a_rd_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en || cmd_o.wr_en) |-> busy_o)
    else $error("memory access while idle");

endmodule

`default_nettype wire

// File: test/olte_checker.sv
// Checker for the ordered list table engine: predicts every result and compares it.
module olte_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  olte_pkg::in_t       cmd_i,
  input  logic                res_valid_i,
  input  olte_pkg::out_t      res_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  import olte_pkg::*;

  logic signed [31:0] list_mem [CAPACITY];
  int unsigned        entries;
  out_t               results_q [$];
  int unsigned        errs;

  function automatic void queue_result(input status_e st, input logic [4:0] pos,
                                       input logic signed [31:0] elem, input logic lst);
    out_t r;
    r.status   = st;
    r.position = pos;
    r.element  = elem;
    r.last     = lst;
    results_q.push_back(r);
  endfunction

  task automatic apply_cmd(input in_t c);
    int idx;
    int hit;
    hit = -1;
    case (c.operation)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (entries >= CAPACITY) begin
          queue_result(ST_FULL, 5'd0, 32'sd0, 1'b1);
        end else begin
          if (c.operation == OP_INS_FRONT) begin
            for (idx = entries; idx > 0; idx--) list_mem[idx] = list_mem[idx - 1];
            list_mem[0] = c.value;
          end else begin
            list_mem[entries] = c.value;
          end
          entries++;
          queue_result(ST_INSERTED, 5'd0, 32'sd0, 1'b1);
        end
      end
      OP_DELETE, OP_SEARCH: begin
        for (idx = 0; idx < entries; idx++) begin
          if (hit < 0 && list_mem[idx] == c.value) hit = idx;
        end
        if (c.operation == OP_SEARCH) begin
          if (hit < 0) queue_result(ST_NOT_FOUND, 5'd0, 32'sd0, 1'b1);
          else queue_result(ST_FOUND, 5'(hit + 1), 32'sd0, 1'b1);
        end else if (hit < 0) begin
          queue_result(ST_ABSENT, 5'd0, 32'sd0, 1'b1);
        end else begin
          for (idx = hit; idx + 1 < entries; idx++) list_mem[idx] = list_mem[idx + 1];
          entries--;
          queue_result(ST_DELETED, 5'd0, 32'sd0, 1'b1);
        end
      end
      OP_LIST: begin
        if (entries == 0) begin
          queue_result(ST_EMPTY, 5'd0, 32'sd0, 1'b1);
        end else begin
          for (idx = 0; idx < entries; idx++) begin
            queue_result(ST_ELEMENT, 5'(idx + 1), list_mem[idx], idx + 1 == entries);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      results_q.delete();
      entries = 0;
      errs = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (results_q.size() == 0) begin
          errs++;
          $display("%0t unexpected result: expected none, actual status %0d pos %0d",
                   $time, res_i.status, res_i.position,
                   " elem %0d last %0d", res_i.element, res_i.last);
        end else begin
          want = results_q.pop_front();
          if (res_i !== want) begin
            errs++;
            $display("%0t result mismatch: expected status %0d pos %0d elem %0d last %0d",
                     $time, want.status, want.position, want.element, want.last);
            $display("%0t                  actual   status %0d pos %0d elem %0d last %0d",
                     $time, res_i.status, res_i.position, res_i.element, res_i.last);
          end
        end
      end
      if (start_i && !busy_i) apply_cmd(cmd_i);
      fail_count_o <= errs;
      pending_o <= results_q.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the ordered list table engine: clock, reset, commands and verdict.
module tb_top;

  import olte_pkg::*;

  localparam int unsigned CAPACITY       = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 34;
  localparam logic [2:0]  OPC_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OPC_SPARE_LAST  = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_t         cmd;
  out_t        res;
  logic        res_valid;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall_cnt;

  ordered_list_table_engine #(.CAPACITY(CAPACITY)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  olte_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) >= 70) return $urandom;
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return 32'sd7;
      6: return 32'sd42;
      default: return -32'sd100;
    endcase
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) < pct) return $urandom_range(1, 24);
    return 0;
  endfunction

  task automatic issue(input logic [2:0] op, input logic signed [31:0] val, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      cmd <= {3'($urandom), 32'($urandom)};
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd <= {op, val};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (CAPACITY + 8) @(posedge clk_i);
  endtask

  initial begin
    int          idle_pct;
    int          ins_pct;
    int unsigned done;
    int          sel;
    logic [2:0]  op;
    rst_ni    = 1'b0;
    start     = 1'b0;
    cmd       = '0;
    stall_cnt = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(OP_LIST, 32'sd0, 0);
    issue(OP_SEARCH, 32'sd5, 0);
    issue(OP_DELETE, 32'sd5, 0);
    issue(OPC_SPARE_FIRST, 32'sd1, 0);
    issue(OPC_SPARE_FIRST + 3'd1, 32'sd1, 0);
    issue(OPC_SPARE_LAST, -32'sd1, 0);
    issue(OP_INS_FRONT, 32'sh7fff_ffff, 0);
    issue(OP_INS_BACK, 32'sh8000_0000, 0);
    issue(OP_INS_FRONT, 32'sd0, 0);
    issue(OP_INS_BACK, -32'sd1, 0);
    for (int k = 0; k < 12; k++) begin
      issue((k % 2 == 0) ? OP_INS_FRONT : OP_INS_BACK, (k % 3 == 0) ? 32'sd7 : 32'(k), 0);
    end
    issue(OP_INS_FRONT, 32'sd99, 0);
    issue(OP_INS_BACK, 32'sd99, 0);
    issue(OP_LIST, 32'sd0, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  ins_pct = 60; end
        1: begin idle_pct = 65; ins_pct = 40; end
        2: begin idle_pct = 17; ins_pct = 20; end
        default: begin idle_pct = 0; ins_pct = 40; end
      endcase
      done = 0;
      while (done < PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 4) begin
          op = 3'($urandom_range(OPC_SPARE_FIRST, OPC_SPARE_LAST));
        end else begin
          done++;
          if (sel < 4 + ins_pct) begin
            op = $urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK;
          end else begin
            sel = $urandom_range(9);
            op = (sel < 4) ? OP_DELETE : (sel < 8) ? OP_SEARCH : OP_LIST;
          end
        end
        issue(op, pick_value(), pick_gap(idle_pct));
        if ($urandom_range(49) == 0) drain();
      end
      drain();
    end

    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/olte_pkg.sv
rtl/core/olte_dp.sv
rtl/core/olte_ctrl.sv
rtl/core/ordered_list_table_engine.sv
test/olte_checker.sv
test/tb_top.sv
